// ----- design/circular_list_engine_top_assert.svh -----
// Assertion macros used by the port-level checker
`ifndef CIRCULAR_LIST_ENGINE_TOP_ASSERT_SVH
`define CIRCULAR_LIST_ENGINE_TOP_ASSERT_SVH
// Assert an implication that spans the next clock
`define CLE_ASSERT_NEXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("assertion failed");
// Assert a same-cycle implication
`define CLE_ASSERT_NOW(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("assertion failed");
`endif

// ----- design/cle_pkg.sv -----
// Shared types and constants of the circular list engine
`timescale 1ns / 1ps
package cle_pkg;
    localparam int CAPACITY_DEF = 32;
    localparam int VAL_W = 32;
    localparam int POS_W = 6;
    localparam int CNT_W = 7;

    typedef enum logic [2:0] {
        K_INS_FIRST = 3'd0, K_INS_LAST = 3'd1, K_INS_AT = 3'd2, K_DEL_FIRST = 3'd3,
        K_DEL_LAST = 3'd4, K_DEL_AT = 3'd5, K_SEARCH = 3'd6, K_READ_ALL = 3'd7
    } kind_t;

    typedef enum logic [1:0] {
        ST_OK = 2'd0, ST_EMPTY = 2'd1, ST_FULL = 2'd2, ST_BAD_POS = 2'd3
    } status_t;

    typedef enum logic [2:0] {
        S_IDLE, S_INS, S_DEL, S_SEARCH, S_READ, S_RESP
    } state_t;

    // controller to datapath
    typedef struct packed {
        logic load;      // capture request
        logic ins_step;  // move one entry up
        logic ins_put;   // write new value
        logic del_step;  // move one entry down
        logic del_done;  // decrement count
        logic walk;      // advance walk index
        logic out_load;  // load output register
        logic out_elem;  // output comes from walked element
    } cmd_t;

    // datapath to controller
    typedef struct packed {
        logic at_target;  // walk index reached the target
        logic walk_end;   // walk index is count-1
        logic match;      // read data equals value
        logic wr_busy;    // a shifted entry is still being written
    } sts_t;
endpackage

// ----- design/cle_datapath.sv -----
// Datapath: element memory, count, walk index and output register
`timescale 1ns / 1ps
module cle_datapath import cle_pkg::*; #(
    parameter int CAPACITY = CAPACITY_DEF
) (
    input  logic                    aclk,
    input  logic                    aresetn,
    input  cmd_t                    cmd,
    output sts_t                    sts,
    input  logic [2:0]              s_kind,
    input  logic signed [VAL_W-1:0] s_value,
    input  logic [POS_W-1:0]        s_position,
    output logic [CNT_W-1:0]        cnt,
    input  logic [1:0]              out_status,
    input  logic                    out_found,
    input  logic                    out_last,
    input  logic                    out_clr,
    output logic [1:0]              m_status,
    output logic signed [VAL_W-1:0] m_elem_value,
    output logic [POS_W-1:0]        m_elem_position,
    output logic                    m_found,
    output logic [CNT_W-1:0]        m_count,
    output logic                    m_last
);
    localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;

    logic [VAL_W-1:0] mem [CAPACITY];
    logic [VAL_W-1:0] rd_reg;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic [POS_W-1:0] idx_reg, rdidx_reg, tgt_reg;
    logic [POS_W-1:0] idx_init;
    logic [2:0] kind_reg;
    logic [VAL_W-1:0] val_reg;

    assign cnt = cnt_reg;

    // capture request and target position
    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            kind_reg <= s_kind;
            val_reg  <= s_value;
            case (s_kind)
                K_INS_FIRST, K_DEL_FIRST: tgt_reg <= '0;
                K_INS_LAST:  tgt_reg <= cnt_reg[POS_W-1:0];
                K_DEL_LAST:  tgt_reg <= POS_W'(cnt_reg - CNT_W'(1));
                default:     tgt_reg <= s_position;
            endcase
        end
    end

    // starting walk index: inserts walk down from count, deletes up from the target, others up from 0
    always_comb begin
        case (s_kind)
            K_INS_FIRST, K_INS_LAST, K_INS_AT: idx_init = cnt_reg[POS_W-1:0];
            K_DEL_LAST: idx_init = POS_W'(cnt_reg - CNT_W'(1));
            K_DEL_AT:   idx_init = s_position;
            default:    idx_init = '0;
        endcase
    end

    // walk index
    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            idx_reg <= idx_init;
        end else if (cmd.ins_step) begin
            idx_reg <= idx_reg - POS_W'(1);
        end else if (cmd.del_step || cmd.walk) begin
            idx_reg <= idx_reg + POS_W'(1);
        end
    end

    // read port: registered, address is idx for walk, idx-1 or idx+1 for shifts
    logic [POS_W-1:0] raddr;
    always_comb begin
        raddr = cmd.load ? idx_init : idx_reg;
        if (cmd.ins_step) raddr = idx_reg - POS_W'(1);
        else if (cmd.del_step) raddr = idx_reg + POS_W'(1);
    end

    always_ff @(posedge aclk) begin
        rd_reg    <= mem[raddr[AW-1:0]];
        rdidx_reg <= raddr;
    end

    // write port: a shift is written in the following cycle at the walk address of its step
    logic wr_pend_reg;
    logic [POS_W-1:0] waddr_reg;
    always_ff @(posedge aclk) begin
        if (!aresetn) wr_pend_reg <= 1'b0;
        else wr_pend_reg <= cmd.ins_step | cmd.del_step;
        waddr_reg <= idx_reg;
    end

    always_ff @(posedge aclk) begin
        if (cmd.ins_put) mem[tgt_reg[AW-1:0]] <= val_reg;
        else if (wr_pend_reg) mem[waddr_reg[AW-1:0]] <= rd_reg;
    end

    // hold the deleted value read at load
    logic [VAL_W-1:0] delv_reg;
    logic first_rd_reg;
    always_ff @(posedge aclk) begin
        first_rd_reg <= cmd.load;
        if (first_rd_reg) delv_reg <= rd_reg;
    end

    // count register
    always_comb begin
        cnt_next = cnt_reg;
        if (cmd.ins_put) cnt_next = cnt_reg + CNT_W'(1);
        else if (cmd.del_done) cnt_next = cnt_reg - CNT_W'(1);
    end
    always_ff @(posedge aclk) begin
        if (!aresetn) cnt_reg <= '0;
        else cnt_reg <= cnt_next;
    end

    assign sts.at_target = (idx_reg == tgt_reg);
    assign sts.walk_end  = ({1'b0, idx_reg} == cnt_reg - CNT_W'(1));
    assign sts.match     = (rd_reg == val_reg);
    assign sts.wr_busy   = wr_pend_reg;

    // output register
    always_ff @(posedge aclk) begin
        if (cmd.out_load) begin
            m_status <= out_status;
            m_found  <= out_found;
            m_last   <= out_last;
            m_count  <= cnt_next;
            if (out_clr) begin
                m_elem_value    <= '0;
                m_elem_position <= '0;
            end else if (cmd.out_elem) begin
                m_elem_value    <= rd_reg;
                m_elem_position <= rdidx_reg;
            end else if (kind_reg == K_SEARCH) begin
                m_elem_value    <= val_reg;
                m_elem_position <= out_found ? rdidx_reg : '0;
            end else if (kind_reg == K_DEL_FIRST || kind_reg == K_DEL_LAST
                         || kind_reg == K_DEL_AT) begin
                m_elem_value    <= delv_reg;
                m_elem_position <= tgt_reg;
            end else begin
                m_elem_value    <= val_reg;
                m_elem_position <= tgt_reg;
            end
        end
    end
endmodule

// ----- design/cle_ctrl.sv -----
// Controller: sequences one transaction at a time over the datapath
`timescale 1ns / 1ps
module cle_ctrl import cle_pkg::*; #(
    parameter int CAPACITY = CAPACITY_DEF
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             s_valid,
    output logic             s_ready,
    input  logic [2:0]       s_kind,
    input  logic [POS_W-1:0] s_position,
    output logic             m_valid,
    input  logic             m_ready,
    input  logic [CNT_W-1:0] cnt,
    input  sts_t             sts,
    output cmd_t             cmd,
    output logic [1:0]       out_status,
    output logic             out_found,
    output logic             out_last,
    output logic             out_clr
);
    state_t state_reg, state_next;
    logic mv_reg, mv_next;
    logic err;
    logic [1:0] err_st;
    logic pend_reg, pend_next;

    // validate request against current count
    always_comb begin
        err = 1'b0;
        err_st = ST_OK;
        case (s_kind)
            K_INS_FIRST, K_INS_LAST, K_INS_AT: begin
                if (cnt >= CNT_W'(CAPACITY)) begin err = 1'b1; err_st = ST_FULL; end
                else if (s_kind == K_INS_AT && (s_position == '0 ||
                         {1'b0, s_position} > cnt)) begin
                    err = 1'b1; err_st = ST_BAD_POS;
                end
            end
            default: begin
                if (cnt == '0) begin err = 1'b1; err_st = ST_EMPTY; end
                else if (s_kind == K_DEL_AT && (s_position == '0 ||
                         {1'b0, s_position} >= cnt)) begin
                    err = 1'b1; err_st = ST_BAD_POS;
                end
            end
        endcase
    end

    logic outbuf_free;
    assign outbuf_free = !mv_reg || m_ready;
    assign s_ready = (state_reg == S_IDLE) && outbuf_free;
    assign m_valid = mv_reg;

    // next state
    always_comb begin
        state_next = state_reg;
        pend_next = pend_reg;
        case (state_reg)
            S_IDLE: if (s_valid && s_ready) begin
                if (err) state_next = S_IDLE;
                else case (s_kind)
                    K_INS_FIRST, K_INS_LAST, K_INS_AT: state_next = S_INS;
                    K_SEARCH: state_next = S_SEARCH;
                    K_READ_ALL: state_next = S_READ;
                    default: state_next = S_DEL;
                endcase
                pend_next = 1'b0;
            end
            S_INS: if (sts.at_target && !sts.wr_busy) state_next = S_RESP;
            S_DEL: if (sts.walk_end) state_next = S_RESP;
            S_SEARCH: if (pend_reg && (sts.match || sts.walk_end) && outbuf_free)
                state_next = S_IDLE;
            S_READ: if (pend_reg && outbuf_free && sts.walk_end) state_next = S_IDLE;
            S_RESP: if (outbuf_free) state_next = S_IDLE;
            default: state_next = S_IDLE;
        endcase
        if (state_reg == S_SEARCH || state_reg == S_READ) begin
            if (!pend_reg) pend_next = 1'b1;
        end
        if (state_reg == S_INS) pend_next = 1'b0;
    end

    // outputs
    always_comb begin
        cmd = '0;
        out_status = ST_OK;
        out_found = 1'b0;
        out_last = 1'b1;
        out_clr = 1'b0;
        mv_next = mv_reg && !m_ready;
        case (state_reg)
            S_IDLE: if (s_valid && s_ready) begin
                cmd.load = 1'b1;
                if (err) begin
                    cmd.out_load = 1'b1;
                    out_status = err_st;
                    out_clr = 1'b1;
                    mv_next = 1'b1;
                end
            end
            // hold the new value until the last shifted entry is written
            S_INS: begin
                if (sts.at_target) begin
                    if (!sts.wr_busy) cmd.ins_put = 1'b1;
                end else cmd.ins_step = 1'b1;
            end
            S_DEL: if (sts.walk_end) cmd.del_done = 1'b1; else cmd.del_step = 1'b1;
            S_SEARCH: if (pend_reg && outbuf_free) begin
                if (sts.match || sts.walk_end) begin
                    cmd.out_load = 1'b1;
                    out_found = sts.match;
                    mv_next = 1'b1;
                end else cmd.walk = 1'b1;
            end else if (!pend_reg) cmd.walk = 1'b0;
            S_READ: if (pend_reg && outbuf_free) begin
                cmd.out_load = 1'b1;
                cmd.out_elem = 1'b1;
                out_last = sts.walk_end;
                mv_next = 1'b1;
                if (!sts.walk_end) cmd.walk = 1'b1;
            end
            S_RESP: if (outbuf_free) begin
                cmd.out_load = 1'b1;
                mv_next = 1'b1;
            end
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
            mv_reg    <= 1'b0;
            pend_reg  <= 1'b0;
        end else begin
            state_reg <= state_next;
            mv_reg    <= mv_next;
            pend_reg  <= (state_reg != state_next) ? 1'b0 :
                         ((cmd.walk) ? 1'b0 : pend_next);
        end
    end
endmodule

// ----- design/circular_list_engine_top.sv -----
// Top level of the circular list engine
`timescale 1ns / 1ps
// Usage:
//   Input channel s_valid/s_ready carries one request: s_kind, s_value,
//   s_position. Result channel m_valid/m_ready carries status, element value,
//   element position, found flag, last flag and the count after the request.
//   Requests are handled one at a time. A rejected request is answered
//   from the idle state. An insert shifts the tail up one entry per cycle,
//   a delete shifts it down one entry per cycle, and search and read-all
//   read the entries in turn, all through the single read and write port
//   of the element memory.
//   Every request except read-all gives one result with m_last high;
//   a non-empty read-all gives one result per element, the final one marked.
//   Reset empties the list at once; memory contents are not cleared.
//   When the receiver stalls, the result register holds and the walk waits.
module circular_list_engine_top import cle_pkg::*; #(
    parameter int CAPACITY = CAPACITY_DEF
) (
    input  logic                    aclk,
    input  logic                    aresetn,
    input  logic                    s_valid,
    output logic                    s_ready,
    input  logic [2:0]              s_kind,
    input  logic signed [VAL_W-1:0] s_value,
    input  logic [POS_W-1:0]        s_position,
    output logic                    m_valid,
    input  logic                    m_ready,
    output logic [1:0]              m_status,
    output logic signed [VAL_W-1:0] m_elem_value,
    output logic [POS_W-1:0]        m_elem_position,
    output logic                    m_found,
    output logic                    m_last,
    output logic [CNT_W-1:0]        m_count
);
    cmd_t cmd;
    sts_t sts;
    logic [CNT_W-1:0] cnt;
    logic [1:0] out_status;
    logic out_found, out_last, out_clr;

    cle_ctrl #(.CAPACITY(CAPACITY)) u_ctrl (
        .aclk, .aresetn, .s_valid, .s_ready, .s_kind, .s_position,
        .m_valid, .m_ready, .cnt, .sts, .cmd,
        .out_status, .out_found, .out_last, .out_clr
    );

    cle_datapath #(.CAPACITY(CAPACITY)) u_dp (
        .aclk, .aresetn, .cmd, .sts, .s_kind, .s_value, .s_position,
        .cnt, .out_status, .out_found, .out_last, .out_clr,
        .m_status, .m_elem_value, .m_elem_position, .m_found, .m_count, .m_last
    );
endmodule

// ----- design/cle_checker.sv -----
// Port-level checker for the circular list engine, bound to the top level
`timescale 1ns / 1ps
`include "circular_list_engine_top_assert.svh"
module cle_checker import cle_pkg::*; (
    input logic       aclk,
    input logic       aresetn,
    input logic       s_valid,
    input logic       s_ready,
    input logic       m_valid,
    input logic       m_ready,
    input logic [1:0] m_status,
    input logic       m_found,
    input logic       m_last,
    input logic [6:0] m_count
);
    `CLE_ASSERT_NEXT(a_out_hold, aclk, aresetn, m_valid && !m_ready, m_valid && $stable(m_count))
    `CLE_ASSERT_NOW(a_err_last, aclk, aresetn, m_valid && m_status != ST_OK, m_last)
    `CLE_ASSERT_NOW(a_found_ok, aclk, aresetn, m_valid && m_found, m_status == ST_OK)
    `CLE_ASSERT_NOW(a_empty_cnt, aclk, aresetn, m_valid && m_status == ST_EMPTY, m_count == '0)
endmodule

bind circular_list_engine_top cle_checker u_cle_checker (
    .aclk, .aresetn, .s_valid, .s_ready, .m_valid, .m_ready,
    .m_status, .m_found, .m_last, .m_count
);

// ----- tb/list_checker.sv -----
// Result checker for the circular list engine: predicts list behavior and compares results
`timescale 1ns / 1ps
module list_checker import cle_pkg::*; #(
    parameter int CAPACITY = CAPACITY_DEF
) (
    input  logic                    aclk,
    input  logic                    aresetn,
    input  logic                    s_valid,
    input  logic                    s_ready,
    input  logic [2:0]              s_kind,
    input  logic signed [VAL_W-1:0] s_value,
    input  logic [POS_W-1:0]        s_position,
    input  logic                    m_valid,
    input  logic                    m_ready,
    input  logic [1:0]              m_status,
    input  logic signed [VAL_W-1:0] m_elem_value,
    input  logic [POS_W-1:0]        m_elem_position,
    input  logic                    m_found,
    input  logic                    m_last,
    input  logic [CNT_W-1:0]        m_count,
    output int                      fail_count,
    output int                      pending
);
    typedef struct packed {
        logic [1:0]       status;
        logic [VAL_W-1:0] value;
        logic [POS_W-1:0] position;
        logic             found;
        logic             last;
        logic [CNT_W-1:0] count;
    } list_result_t;

    logic [VAL_W-1:0] shadow_list [CAPACITY];
    int               shadow_count;
    list_result_t     expected_results [$];

    assign pending = expected_results.size();

    function automatic list_result_t mk(logic [1:0] st, logic [VAL_W-1:0] v,
                                        int p, int f, int l);
        list_result_t r;
        r.status = st; r.value = v; r.position = p[POS_W-1:0];
        r.found = f[0]; r.last = l[0]; r.count = shadow_count[CNT_W-1:0];
        return r;
    endfunction

    // Apply one request to the shadow list and queue its results
    task automatic predict_request(kind_t k, logic [VAL_W-1:0] v, int p);
        int n;
        int i;
        int hit;
        logic [VAL_W-1:0] gone;
        n = shadow_count;
        hit = -1;
        case (k)
            K_INS_FIRST, K_INS_LAST, K_INS_AT: begin
                if (n >= CAPACITY) begin
                    expected_results.push_back(mk(ST_FULL, 0, 0, 0, 1));
                end else if (k == K_INS_AT && (p < 1 || p > n)) begin
                    expected_results.push_back(mk(ST_BAD_POS, 0, 0, 0, 1));
                end else begin
                    if (k == K_INS_FIRST) p = 0;
                    if (k == K_INS_LAST) p = n;
                    for (i = n; i > p; i--) shadow_list[i] = shadow_list[i-1];
                    shadow_list[p] = v;
                    shadow_count++;
                    expected_results.push_back(mk(ST_OK, v, p, 0, 1));
                end
            end
            K_DEL_FIRST, K_DEL_LAST, K_DEL_AT: begin
                if (n == 0) begin
                    expected_results.push_back(mk(ST_EMPTY, 0, 0, 0, 1));
                end else if (k == K_DEL_AT && (p < 1 || p >= n)) begin
                    expected_results.push_back(mk(ST_BAD_POS, 0, 0, 0, 1));
                end else begin
                    if (k == K_DEL_FIRST) p = 0;
                    if (k == K_DEL_LAST) p = n - 1;
                    gone = shadow_list[p];
                    for (i = p; i + 1 < n; i++) shadow_list[i] = shadow_list[i+1];
                    shadow_count--;
                    expected_results.push_back(mk(ST_OK, gone, p, 0, 1));
                end
            end
            K_SEARCH: begin
                if (n == 0) begin
                    expected_results.push_back(mk(ST_EMPTY, 0, 0, 0, 1));
                end else begin
                    for (i = n - 1; i >= 0; i--) if (shadow_list[i] == v) hit = i;
                    if (hit >= 0) expected_results.push_back(mk(ST_OK, v, hit, 1, 1));
                    else expected_results.push_back(mk(ST_OK, v, 0, 0, 1));
                end
            end
            default: begin
                if (n == 0) expected_results.push_back(mk(ST_EMPTY, 0, 0, 0, 1));
                for (i = 0; i < n; i++)
                    expected_results.push_back(mk(ST_OK, shadow_list[i], i, 0,
                                                  (i + 1 == n) ? 1 : 0));
            end
        endcase
    endtask

    // Predict on every accepted request, compare every accepted result
    always @(posedge aclk) begin
        list_result_t want;
        list_result_t got;
        if (!aresetn) begin
            shadow_count <= 0;
            fail_count <= 0;
            expected_results.delete();
        end else begin
            if (m_valid && m_ready) begin
                got = '{m_status, m_elem_value, m_elem_position, m_found, m_last, m_count};
                if (expected_results.size() == 0) begin
                    $display("%0t: unexpected result %h", $time, got);
                    fail_count++;
                end else begin
                    want = expected_results.pop_front();
                    if (got.status !== want.status)
                        $display("%0t: status exp %0d got %0d", $time, want.status, got.status);
                    if (got.value !== want.value)
                        $display("%0t: value exp %h got %h", $time, want.value, got.value);
                    if (got.position !== want.position)
                        $display("%0t: position exp %0d got %0d", $time, want.position,
                                 got.position);
                    if (got.found !== want.found)
                        $display("%0t: found exp %b got %b", $time, want.found, got.found);
                    if (got.last !== want.last)
                        $display("%0t: last exp %b got %b", $time, want.last, got.last);
                    if (got.count !== want.count)
                        $display("%0t: count exp %0d got %0d", $time, want.count, got.count);
                    if (got !== want) fail_count++;
                end
            end
            if (s_valid && s_ready)
                predict_request(kind_t'(s_kind), s_value, int'(s_position));
        end
    end
endmodule

// ----- tb/tb.sv -----
// Testbench top for the circular list engine: stimulus, idling and verdict
`timescale 1ns / 1ps
module tb;
    import cle_pkg::*;
    localparam int CAP = CAPACITY_DEF;
    localparam int WATCHDOG = 20000;

    logic                    aclk;
    logic                    aresetn;
    logic                    s_valid;
    logic                    s_ready;
    logic [2:0]              s_kind;
    logic signed [VAL_W-1:0] s_value;
    logic [POS_W-1:0]        s_position;
    logic                    m_valid;
    logic                    m_ready;
    logic [1:0]              m_status;
    logic signed [VAL_W-1:0] m_elem_value;
    logic [POS_W-1:0]        m_elem_position;
    logic                    m_found;
    logic                    m_last;
    logic [CNT_W-1:0]        m_count;
    int                      fail_count;
    int                      pending;
    int                      send_idle_pct;
    int                      recv_idle_pct;
    bit                      recv_hold;
    int                      quiet_cycles;
    logic [VAL_W-1:0]        recent_values [8];

    circular_list_engine_top #(.CAPACITY(CAP)) DUT (.*);

    list_checker #(.CAPACITY(CAP)) checker_inst (.*);

    initial begin
        aclk = 0;
        forever #5 aclk = ~aclk;
    end

    // Drive the receiver ready at random, or hold it off on request
    always @(posedge aclk) begin
        if (!aresetn) m_ready <= 0;
        else m_ready <= !recv_hold && ($urandom_range(99) >= recv_idle_pct);
    end

    // End the run if nothing moves for too long
    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready)) quiet_cycles <= 0;
        else quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG) begin
            $display("== FAIL ==");
            $finish;
        end
    end

    // Offer one transaction and wait until it is accepted
    task automatic send_request(kind_t k, logic [VAL_W-1:0] v, int p);
        while ($urandom_range(99) < send_idle_pct) begin
            s_valid <= 0;
            @(posedge aclk);
        end
        s_valid <= 1; s_kind <= k; s_value <= v; s_position <= POS_W'(p);
        recent_values[3'($urandom_range(7))] = v;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
    endtask

    // Drop valid and wait until every expected result has come
    task automatic wait_drained();
        s_valid <= 0;
        @(posedge aclk);
        while (pending != 0) @(posedge aclk);
    endtask

    // Random request, mostly valid positions, search often hits
    task automatic send_random();
        kind_t k;
        logic [VAL_W-1:0] v;
        int p;
        int r;
        r = $urandom_range(99);
        if (r < 40) k = kind_t'($urandom_range(2));
        else if (r < 75) k = kind_t'($urandom_range(5, 3));
        else if (r < 92) k = K_SEARCH;
        else k = K_READ_ALL;
        v = $urandom;
        if ($urandom_range(3) == 0) v = recent_values[3'($urandom_range(7))];
        p = ($urandom_range(9) == 0) ? int'($urandom_range(63))
                                     : int'($urandom_range(CAP / 2, 1));
        send_request(k, v, p);
    endtask

    initial begin
        s_valid = 0; s_kind = 0; s_value = 0; s_position = 0;
        recv_hold = 0;
        send_idle_pct = 9; recv_idle_pct = 82;
        foreach (recent_values[i]) recent_values[i] = 0;
        aresetn = 0;
        repeat (2) @(posedge aclk);
        aresetn <= 1;
        @(posedge aclk);

        // Directed: empty-list cases, extremes, full list, bad positions
        send_request(K_DEL_FIRST, 0, 0);
        send_request(K_DEL_LAST, 0, 0);
        send_request(K_DEL_AT, 0, 1);
        send_request(K_SEARCH, 5, 0);
        send_request(K_READ_ALL, 0, 0);
        send_request(K_INS_AT, 7, 0);
        send_request(K_INS_FIRST, 32'h7fffffff, 0);
        send_request(K_DEL_LAST, 0, 0);
        send_request(K_INS_LAST, 32'h80000000, 0);
        send_request(K_DEL_FIRST, 0, 0);
        send_request(K_INS_LAST, 32'hffffffff, 63);
        send_request(K_INS_AT, 1, 1);
        send_request(K_INS_AT, 2, 63);
        send_request(K_DEL_AT, 0, 0);
        send_request(K_DEL_AT, 0, 2);
        send_request(K_SEARCH, 32'hffffffff, 0);
        send_request(K_SEARCH, 12345, 0);
        send_request(K_DEL_AT, 0, 1);
        send_request(K_READ_ALL, 0, 0);
        // Fill the list while the receiver holds off for a counted stretch
        recv_hold = 1;
        fork
            begin
                repeat (300) @(posedge aclk);
                recv_hold = 0;
            end
        join_none
        repeat (CAP) send_request(K_INS_LAST, $urandom, $urandom);
        send_request(K_INS_FIRST, 1, 0);
        send_request(K_INS_AT, 1, 5);
        send_request(K_READ_ALL, 0, 0);
        wait_drained();

        // Random phases with different idling mixes
        repeat (72) send_random();
        wait_drained();
        send_idle_pct = 82; recv_idle_pct = 9;
        repeat (72) send_random();
        wait_drained();
        send_idle_pct = 0; recv_idle_pct = 0;
        repeat (72) send_random();

        wait_drained();
        repeat (2 * CAP + 10) @(posedge aclk);
        if (fail_count == 0 && pending == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end
endmodule
